// ----- design/nvsc_pkg.sv -----
// shared constants, codes and types of the checksummed nonvolatile byte store
package nvsc_pkg;

    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 16;
    localparam int CMD_W           = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int IN_TDATA_W      = 24;
    localparam int OUT_TDATA_W     = 24;
    localparam int DEF_STORE_WORDS = 128;
    // an 8-bit byte address reaches 128 words at most
    localparam int MAX_MEM_WORDS   = 128;

    localparam logic [BYTE_W-1:0] SUM_SEED        = 8'hA5;
    localparam logic [BYTE_W-1:0] RST_CKS_OFF     = 8'h00;
    localparam logic [BYTE_W-1:0] RST_REV_OFF     = 8'h01;
    localparam logic [BYTE_W-1:0] RST_CUR_REV     = 8'h01;
    localparam logic [BYTE_W-1:0] RST_CHK_WORDS   = 8'h80;

    localparam logic [CFG_IDX_W-1:0] REG_CKS_OFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REV_OFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_REV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_WORDS = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_SEAL  = 2'd3
    } t_cmd;

    function automatic logic [BYTE_W-1:0] rotl1(input logic [BYTE_W-1:0] v);
        return {v[BYTE_W-2:0], v[BYTE_W-1]};
    endfunction

endpackage

// ----- design/nvram_store_with_checksum_unit.sv -----
// top level: command sequencer and checksum walk around the word store
//
// Byte-addressed store of 16-bit big-endian words with check and seal commands.
// One word at a time: a byte read or write passes through a request and a use state
// before the result register loads, and a check or a seal walks n words, where
// n = min(checked_words, STORE_WORDS); the checksum walk reads one word per cycle
// through the single read port of the store. The input is ready again the cycle
// after the result register loads, and a result still waiting there holds the next
// one back. The store reads as zero after reset with no clearing pass.
// Configuration writes take effect at once.
module nvram_store_with_checksum_unit #(
    parameter int STORE_WORDS = nvsc_pkg::DEF_STORE_WORDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // command, byte_address, write_data
    input  logic [nvsc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // read_data, contents_valid, computed_checksum
    output logic [nvsc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [nvsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nvsc_pkg::BYTE_W-1:0]      i_cfg_data
);
    import nvsc_pkg::*;

    localparam int MEM_WORDS = (STORE_WORDS < MAX_MEM_WORDS) ? STORE_WORDS : MAX_MEM_WORDS;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BREQ,
        S_BUSE,
        S_SUM,
        S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [BYTE_W-1:0]   r_cks_off;
    logic [BYTE_W-1:0]   r_rev_off;
    logic [BYTE_W-1:0]   r_cur_rev;
    logic [BYTE_W-1:0]   r_chk_words;
    logic [BYTE_W-1:0]   r_baddr;
    logic [BYTE_W-1:0]   r_wdata;
    logic                r_step;
    logic [BYTE_W-1:0]   r_lim;
    logic [BYTE_W-1:0]   r_idx;
    logic                r_pv;
    logic                r_pin;
    logic [BYTE_W-1:0]   r_pidx;
    logic [BYTE_W-1:0]   r_sum;
    logic                r_match;
    logic [BYTE_W-1:0]   r_rd;
    logic                r_valid;
    logic                r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    logic                accept;
    t_cmd                in_cmd;
    logic [BYTE_W-1:0]   in_addr;
    logic [BYTE_W-1:0]   in_data;
    logic [BYTE_W-1:0]   chk_lim;
    logic                b_in;
    logic [BYTE_W-1:0]   b_byte;
    logic [BYTE_W-1:0]   wbyte;
    logic [WORD_W-1:0]   merged;
    logic                idx_in;
    logic                walk_more;
    logic [WORD_W-1:0]   p_word;
    logic [BYTE_W-1:0]   contrib;
    logic [BYTE_W-1:0]   sum_out;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [WORD_W-1:0]   m_rdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd          = t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
    assign in_addr         = i_s_axis_tdata[CMD_W+BYTE_W-1:CMD_W];
    assign in_data         = i_s_axis_tdata[CMD_W+2*BYTE_W-1:CMD_W+BYTE_W];

    assign chk_lim = (int'(r_chk_words) > STORE_WORDS) ? BYTE_W'(STORE_WORDS) : r_chk_words;

    // byte access path
    assign b_in   = int'(r_baddr[BYTE_W-1:1]) < STORE_WORDS;
    assign b_byte = !b_in ? '0 : (r_baddr[0] ? m_rdata[BYTE_W-1:0] : m_rdata[WORD_W-1:BYTE_W]);

    always_comb begin
        case (r_cmd)
            CMD_SEAL: wbyte = r_step ? r_sum : r_cur_rev;
            default:  wbyte = r_wdata;
        endcase
    end

    assign merged = r_baddr[0] ? {m_rdata[WORD_W-1:BYTE_W], wbyte}
                               : {wbyte, m_rdata[BYTE_W-1:0]};
    assign mem_we = (r_state == S_BUSE) && b_in && ((r_cmd == CMD_WRITE) || (r_cmd == CMD_SEAL));

    // checksum walk
    assign idx_in    = int'(r_idx) < MEM_WORDS;
    assign walk_more = (r_idx != r_lim);
    assign p_word    = r_pin ? m_rdata : '0;

    always_comb begin
        if (r_pidx == {1'b0, r_cks_off[BYTE_W-1:1]}) begin
            contrib = r_cks_off[0] ? p_word[WORD_W-1:BYTE_W] : p_word[BYTE_W-1:0];
        end else begin
            contrib = p_word[WORD_W-1:BYTE_W] ^ p_word[BYTE_W-1:0];
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_baddr[AW:1];
        case (r_state)
            S_BREQ: begin
                mem_re = b_in;
            end
            S_SUM: begin
                mem_re    = walk_more && idx_in;
                mem_raddr = r_idx[AW-1:0];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    assign sum_out = ((r_cmd == CMD_CHECK) || (r_cmd == CMD_SEAL)) ? r_sum : '0;

    nvsc_mem #(
        .DEPTH(MEM_WORDS),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .i_we   (mem_we),
        .i_waddr(r_baddr[AW:1]),
        .i_wdata(merged),
        .o_rdata(m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cks_off   <= RST_CKS_OFF;
            r_rev_off   <= RST_REV_OFF;
            r_cur_rev   <= RST_CUR_REV;
            r_chk_words <= RST_CHK_WORDS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CKS_OFF:   r_cks_off   <= i_cfg_data;
                REG_REV_OFF:   r_rev_off   <= i_cfg_data;
                REG_CUR_REV:   r_cur_rev   <= i_cfg_data;
                REG_CHK_WORDS: r_chk_words <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= in_cmd;
                        r_wdata <= in_data;
                        r_step  <= 1'b0;
                        r_lim   <= chk_lim;
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_sum   <= SUM_SEED;
                        r_rd    <= '0;
                        r_valid <= 1'b0;
                        r_match <= 1'b0;
                        case (in_cmd)
                            CMD_CHECK: begin
                                r_state <= S_SUM;
                            end
                            CMD_SEAL: begin
                                r_baddr <= r_rev_off;
                                r_state <= S_BREQ;
                            end
                            default: begin
                                r_baddr <= in_addr;
                                r_state <= S_BREQ;
                            end
                        endcase
                    end
                end
                S_BREQ: begin
                    r_state <= S_BUSE;
                end
                S_BUSE: begin
                    case (r_cmd)
                        CMD_READ: begin
                            r_rd    <= b_byte;
                            r_state <= S_OUT;
                        end
                        CMD_CHECK: begin
                            if (!r_step) begin
                                r_match <= (b_byte == r_sum);
                                r_step  <= 1'b1;
                                r_baddr <= r_rev_off;
                                r_state <= S_BREQ;
                            end else begin
                                r_valid <= r_match && (b_byte == r_cur_rev);
                                r_state <= S_OUT;
                            end
                        end
                        CMD_SEAL: begin
                            r_state <= r_step ? S_OUT : S_SUM;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_SUM: begin
                    r_pv   <= walk_more;
                    r_pin  <= idx_in;
                    r_pidx <= r_idx;
                    if (walk_more) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pv) begin
                        r_sum <= rotl1(r_sum ^ contrib);
                    end
                    if (!walk_more && !r_pv) begin
                        r_step  <= (r_cmd == CMD_SEAL);
                        r_baddr <= r_cks_off;
                        r_state <= S_BREQ;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {(OUT_TDATA_W-2*BYTE_W-1)'(0), sum_out, r_valid, r_rd};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start a command");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_idx <= r_lim))
        else $error("checksum walk ran past its limit");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re)
        else $error("store read and write in the same cycle");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_ovalid && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("pending result word overwritten");
`endif

endmodule

// ----- design/nvsc_mem.sv -----
// word store: one write port, one registered read port, per-word valid bits cleared by reset
module nvsc_mem #(
    parameter int DEPTH = nvsc_pkg::MAX_MEM_WORDS,
    parameter int AW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [nvsc_pkg::WORD_W-1:0] i_wdata,
    output logic [nvsc_pkg::WORD_W-1:0] o_rdata
);
    import nvsc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // a word never written reads as zero
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule
